[rtl/core/sph_kernel_table_eval_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the kernel table evaluator checker
// Implication forms with the clock and reset built in.
// ---------------------------------------------------------------------------
`ifndef SPH_KERNEL_TABLE_EVAL_TOP_ASSERT_SVH
`define SPH_KERNEL_TABLE_EVAL_TOP_ASSERT_SVH

// same-cycle implication
`define SKT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sph_kte assertion failed");

// next-cycle implication
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sph_kte assertion failed");

`endif

[rtl/core/sph_kte_pkg.sv]
// ---------------------------------------------------------------------------
// sph_kte_pkg
// Types, constants and helpers shared by the kernel table evaluator.
// ---------------------------------------------------------------------------
`default_nettype none
package sph_kte_pkg;
	localparam int TABLE_SIZE = 1024;
	localparam int TBL_AW     = $clog2(TABLE_SIZE);
	localparam int POS_W      = 17 + TBL_AW;
	localparam int SQRT_STEPS = 32;

	localparam logic [1:0] MODE_LOAD_K = 2'd0;
	localparam logic [1:0] MODE_LOAD_G = 2'd1;
	localparam logic [1:0] MODE_EVAL   = 2'd2;

	localparam logic [1:0]  REG_INV_RADIUS   = 2'd0;
	localparam logic [31:0] INV_RADIUS_RESET = 32'd65536;

	typedef struct packed {
		logic [1:0]         mode;
		logic [TBL_AW-1:0]  idx;
		logic signed [31:0] val;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} meta_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction
endpackage
`default_nettype wire

[rtl/core/sph_kernel_table_eval_top.sv]
// ---------------------------------------------------------------------------
// sph_kernel_table_eval_top
// Pipelined SPH kernel / gradient lookup with interpolated tables.
// ---------------------------------------------------------------------------
// channel | dir | handshake            | contents
// s_      | in  | s_tvalid/s_tready    | tuser: mode; tdata: index, value, x, y, z
// m_      | out | m_tvalid/m_tready    | tdata: kernel, grad x, grad y, grad z
// apb     | in  | psel/penable/pready  | inv_radius at byte address 0
//
// One word per cycle in while the output register is empty or taken.
// The depth is set by the square root: one restoring step per stage, 32 stages.
// The whole pipeline advances together when the output register is empty or
// taken; a stall freezes every stage, so nothing is lost or repeated.
// Loads ride the pipeline and write the tables at the read stage, keeping
// order with evaluations. Tables have no reset; arst_n clears valids and inv_radius.
// ---------------------------------------------------------------------------
`default_nettype none
module sph_kernel_table_eval_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,   // table_index, table_value, off_x, off_y, off_z, pad
	input  wire logic [1:0]   s_tuser,   // mode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [127:0]      m_tdata,   // kernel_value, grad_x, grad_y, grad_z
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int AW = sph_kte_pkg::TBL_AW;
	localparam int PW = sph_kte_pkg::POS_W;
	localparam int NS = sph_kte_pkg::SQRT_STEPS;

	logic adv;
	logic [31:0] inv_radius_q;

	// config
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_radius_q <= sph_kte_pkg::INV_RADIUS_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[3:2] == sph_kte_pkg::REG_INV_RADIUS) begin
			inv_radius_q <= pwdata;
		end
	end
	assign prdata = (paddr[3:2] == sph_kte_pkg::REG_INV_RADIUS) ? inv_radius_q : 32'd0;

	// stall control
	logic vld_s43;
	assign adv      = !vld_s43 || m_tready;
	assign s_tready = adv;

	// s1 input, s2 squares, s3 sum
	sph_kte_pkg::meta_t meta_s1, meta_s2;
	logic vld_s1, vld_s2;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;

	logic [63:0]        sr_rem_s  [0:NS];
	logic [63:0]        sr_root_s [0:NS];
	sph_kte_pkg::meta_t sr_meta_s [0:NS];
	logic               sr_vld_s  [0:NS];

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.mode <= s_tuser;
			meta_s1.idx  <= s_tdata[AW-1:0];
			meta_s1.val  <= s_tdata[41:10];
			meta_s1.x    <= s_tdata[73:42];
			meta_s1.y    <= s_tdata[105:74];
			meta_s1.z    <= s_tdata[137:106];
			meta_s2      <= meta_s1;
			sqx_s2       <= 64'(meta_s1.x) * 64'(meta_s1.x);
			sqy_s2       <= 64'(meta_s1.y) * 64'(meta_s1.y);
			sqz_s2       <= 64'(meta_s1.z) * 64'(meta_s1.z);
			sr_meta_s[0] <= meta_s2;
			sr_rem_s[0]  <= sqx_s2 + sqy_s2 + sqz_s2;
			sr_root_s[0] <= 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			sr_vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s1      <= s_tvalid;
			vld_s2      <= vld_s1;
			sr_vld_s[0] <= vld_s2;
		end
	end

	// restoring square root, one result bit per stage
	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		assign trial = sr_root_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (adv) begin
				sr_meta_s[k+1] <= sr_meta_s[k];
				if (sr_rem_s[k] >= trial) begin
					sr_rem_s[k+1]  <= sr_rem_s[k] - trial;
					sr_root_s[k+1] <= (sr_root_s[k] >> 1) + BIT;
				end else begin
					sr_rem_s[k+1]  <= sr_rem_s[k];
					sr_root_s[k+1] <= sr_root_s[k] >> 1;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sr_vld_s[k+1] <= 1'b0;
			else if (adv)
				sr_vld_s[k+1] <= sr_vld_s[k];
		end
	end

	// s36 q product, s37 table position, s38 table read, s39 diff,
	// s40 lambda product, s41 interpolated value, s42 gradient product, s43 out
	sph_kte_pkg::meta_t meta_s36, meta_s37, meta_s38, meta_s39, meta_s40,
		meta_s41, meta_s42;
	logic vld_s36, vld_s37, vld_s38, vld_s39, vld_s40, vld_s41, vld_s42;
	logic [63:0] prod_s36;
	logic [47:0] q_w;
	logic [PW-1:0] pos_w;
	logic [AW-1:0] lo_s37, lo_nx;
	logic [15:0] lam_s37, lam_s38, lam_s39;
	logic top_s37, top_s38;
	logic far_s37, far_s38, far_s39, far_s40, far_s41, far_s42;
	logic zq_s37, zq_s38, zq_s39, zq_s40, zq_s41, zq_s42;
	logic signed [31:0] ka_s38, kb_s38, ga_s38, gb_s38;
	logic signed [31:0] ka_s39, ga_s39, ka_s40, ga_s40;
	logic signed [32:0] kd_s39, gd_s39;
	logic signed [49:0] km_s40, gm_s40;
	logic signed [31:0] kv_s41, fv_s41, kv_s42;
	logic signed [63:0] gx_s42, gy_s42, gz_s42;
	logic signed [31:0] k_s43, gxo_s43, gyo_s43, gzo_s43;

	logic [31:0] kmem [sph_kte_pkg::TABLE_SIZE];
	logic [31:0] gmem [sph_kte_pkg::TABLE_SIZE];

	assign q_w   = prod_s36[63:16];
	assign pos_w = PW'(q_w[16:0]) * PW'(sph_kte_pkg::TABLE_SIZE - 1);
	assign lo_nx = lo_s37 + AW'(1);

	// table writes land at the read stage so loads and lookups stay in order
	always_ff @(posedge clk) begin
		if (adv && vld_s37 && meta_s37.mode == sph_kte_pkg::MODE_LOAD_K)
			kmem[meta_s37.idx] <= meta_s37.val;
		if (adv && vld_s37 && meta_s37.mode == sph_kte_pkg::MODE_LOAD_G)
			gmem[meta_s37.idx] <= meta_s37.val;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ka_s38 <= kmem[lo_s37];
			kb_s38 <= kmem[lo_nx];
			ga_s38 <= gmem[lo_s37];
			gb_s38 <= gmem[lo_nx];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s36 <= 64'(sr_root_s[NS][31:0]) * 64'(inv_radius_q);
			meta_s36 <= sr_meta_s[NS];

			far_s37  <= q_w > 48'd65536;
			zq_s37   <= q_w == 48'd0;
			lo_s37   <= pos_w[16+AW-1:16];
			lam_s37  <= pos_w[15:0];
			top_s37  <= pos_w[16+AW-1:16] == AW'(sph_kte_pkg::TABLE_SIZE - 1);
			meta_s37 <= meta_s36;

			lam_s38  <= lam_s37;
			top_s38  <= top_s37;
			far_s38  <= far_s37;
			zq_s38   <= zq_s37;
			meta_s38 <= meta_s37;

			// top entry: no neighbor, difference forced to zero
			kd_s39   <= top_s38 ? 33'sd0 : 33'(kb_s38) - 33'(ka_s38);
			gd_s39   <= top_s38 ? 33'sd0 : 33'(gb_s38) - 33'(ga_s38);
			ka_s39   <= ka_s38;
			ga_s39   <= ga_s38;
			lam_s39  <= lam_s38;
			far_s39  <= far_s38;
			zq_s39   <= zq_s38;
			meta_s39 <= meta_s38;

			km_s40   <= 50'($signed({1'b0, lam_s39})) * 50'(kd_s39);
			gm_s40   <= 50'($signed({1'b0, lam_s39})) * 50'(gd_s39);
			ka_s40   <= ka_s39;
			ga_s40   <= ga_s39;
			far_s40  <= far_s39;
			zq_s40   <= zq_s39;
			meta_s40 <= meta_s39;

			kv_s41   <= sph_kte_pkg::sat32(64'(ka_s40) + 64'(km_s40 >>> 16));
			fv_s41   <= sph_kte_pkg::sat32(64'(ga_s40) + 64'(gm_s40 >>> 16));
			far_s41  <= far_s40;
			zq_s41   <= zq_s40;
			meta_s41 <= meta_s40;

			gx_s42   <= 64'(fv_s41) * 64'(meta_s41.x);
			gy_s42   <= 64'(fv_s41) * 64'(meta_s41.y);
			gz_s42   <= 64'(fv_s41) * 64'(meta_s41.z);
			kv_s42   <= kv_s41;
			far_s42  <= far_s41;
			zq_s42   <= zq_s41;
			meta_s42 <= meta_s41;

			k_s43    <= far_s42 ? 32'sd0 : kv_s42;
			gxo_s43  <= (far_s42 || zq_s42) ? 32'sd0 : sph_kte_pkg::sat32(gx_s42 >>> 16);
			gyo_s43  <= (far_s42 || zq_s42) ? 32'sd0 : sph_kte_pkg::sat32(gy_s42 >>> 16);
			gzo_s43  <= (far_s42 || zq_s42) ? 32'sd0 : sph_kte_pkg::sat32(gz_s42 >>> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s36 <= 1'b0;
			vld_s37 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s40 <= 1'b0;
			vld_s41 <= 1'b0;
			vld_s42 <= 1'b0;
			vld_s43 <= 1'b0;
		end else if (adv) begin
			vld_s36 <= sr_vld_s[NS];
			vld_s37 <= vld_s36;
			vld_s38 <= vld_s37;
			vld_s39 <= vld_s38;
			vld_s40 <= vld_s39;
			vld_s41 <= vld_s40;
			vld_s42 <= vld_s41;
			// only evaluate words produce a result
			vld_s43 <= vld_s42 && meta_s42.mode == sph_kte_pkg::MODE_EVAL;
		end
	end

	assign m_tvalid = vld_s43;
	assign m_tdata  = {gzo_s43, gyo_s43, gxo_s43, k_s43};
endmodule
`default_nettype wire

[rtl/core/sph_kte_chk.sv]
// ---------------------------------------------------------------------------
// sph_kte_chk
// Port-level checker for the kernel table evaluator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sph_kernel_table_eval_top_assert.svh"
module sph_kte_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata,
	input wire logic         pready
);
	`SKT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`SKT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	`SKT_ASSERT_NOW(a_backpressure, m_tvalid && !m_tready, !s_tready)
	`SKT_ASSERT_NOW(a_free_flow, !m_tvalid || m_tready, s_tready && pready)
endmodule

bind sph_kernel_table_eval_top sph_kte_chk u_sph_kte_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: kernel table evaluator testbench
// Fills both tables over the stream port, then drives directed and random
// loads and evaluations through several inverse-radius settings and several
// idle/stall mixes. An in-bench predictor computes each expected result
// word, and a checker compares every output word field by field, in order.
// ---------------------------------------------------------------------------
module tb;
	localparam int          TABLE_SIZE       = sph_kte_pkg::TABLE_SIZE;
	localparam logic [1:0]  MODE_LOAD_K      = sph_kte_pkg::MODE_LOAD_K;
	localparam logic [1:0]  MODE_LOAD_G      = sph_kte_pkg::MODE_LOAD_G;
	localparam logic [1:0]  MODE_EVAL        = sph_kte_pkg::MODE_EVAL;
	localparam logic [1:0]  REG_INV_RADIUS   = sph_kte_pkg::REG_INV_RADIUS;
	localparam logic [31:0] INV_RADIUS_RESET = sph_kte_pkg::INV_RADIUS_RESET;

	localparam int LAT        = 42;
	localparam int DOG_LIMIT  = 5000;
	localparam logic [1:0] MODE_NONE = 2'd3;   // unused code, must be ignored

	typedef struct {
		logic signed [31:0] kern;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [31:0] gz;
	} kresult_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;   // table_index, table_value, off_x, off_y, off_z, pad
	logic [1:0]   s_tuser;   // mode
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // kernel_value, grad_x, grad_y, grad_z
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	sph_kernel_table_eval_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state: own copy of both tables and the register
	logic signed [31:0] kern_tab [0:TABLE_SIZE-1];
	logic signed [31:0] grad_tab [0:TABLE_SIZE-1];
	logic [31:0]        inv_rad;

	kresult_t pending_results[$];

	int errors;
	int n_words_in;
	int n_results;
	int n_outside;
	int n_zero_q;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_off;       // requested receiver hold-off, in cycles
	int dog;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// exact floor square root, restoring form
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 64'd0;
		b = 64'h4000_0000_0000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp32(input longint v);
		longint r;
		if (v > 64'sd2147483647)
			r = 64'sd2147483647;
		else if (v < -64'sd2147483648)
			r = -64'sd2147483648;
		else
			r = v;
		return r;
	endfunction

	// linear interpolation at q*(TABLE_SIZE-1); top entry returned as is
	function automatic longint interp(input bit use_grad, input logic [63:0] q);
		logic [63:0] pos;
		logic [63:0] lo;
		longint      lam;
		longint      a;
		longint      b;
		longint      r;
		pos = q * 64'(TABLE_SIZE - 1);
		lo = pos >> 16;
		lam = longint'(pos[15:0]);
		if (lo >= 64'(TABLE_SIZE - 1)) begin
			r = use_grad ? longint'(grad_tab[TABLE_SIZE-1]) : longint'(kern_tab[TABLE_SIZE-1]);
		end else begin
			a = use_grad ? longint'(grad_tab[lo]) : longint'(kern_tab[lo]);
			b = use_grad ? longint'(grad_tab[lo+1]) : longint'(kern_tab[lo+1]);
			r = clamp32(a + ((lam * (b - a)) >>> 16));
		end
		return r;
	endfunction

	// apply one accepted word to the predictor; push the expected result
	task automatic predict_word(input logic [1:0] mode, input logic [9:0] idx,
			input logic signed [31:0] val, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		kresult_t    r;
		logic [63:0] sum;
		logic [63:0] len;
		logic [63:0] q;
		longint      f;
		if (mode == MODE_LOAD_K) begin
			kern_tab[idx] = val;
		end else if (mode == MODE_LOAD_G) begin
			grad_tab[idx] = val;
		end else if (mode == MODE_EVAL) begin
			sum = 64'(longint'(x) * longint'(x)) + 64'(longint'(y) * longint'(y))
				+ 64'(longint'(z) * longint'(z));
			len = root64(sum);
			q = (len * 64'(inv_rad)) >> 16;   // 64-bit product, as the block does
			r.kern = '0;
			r.gx = '0;
			r.gy = '0;
			r.gz = '0;
			if (q <= 64'd65536) begin
				r.kern = 32'(interp(1'b0, q));
				if (q != 0) begin
					f = interp(1'b1, q);
					r.gx = 32'(clamp32((f * longint'(x)) >>> 16));
					r.gy = 32'(clamp32((f * longint'(y)) >>> 16));
					r.gz = 32'(clamp32((f * longint'(z)) >>> 16));
				end else begin
					n_zero_q++;
				end
			end else begin
				n_outside++;
			end
			pending_results.push_back(r);
		end
	endtask

	// one word on the input stream, with random idle before it
	task automatic send_word(input logic [1:0] mode, input logic [9:0] idx,
			input logic signed [31:0] val, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {6'd0, z, y, x, val, idx};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_words_in++;
		predict_word(mode, idx, val, x, y, z);
	endtask

	task automatic source_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	// wait until every expected result is back, then let the pipe settle
	task automatic drain();
		source_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	// APB write: setup then access; only called with the block idle
	task automatic reg_write(input logic [1:0] addr_idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {addr_idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr_idx == REG_INV_RADIUS)
			inv_rad = data;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// offset component with random magnitude: shift spreads it over all scales
	function automatic logic signed [31:0] rand_comp();
		logic signed [31:0] v;
		v = $signed($urandom());
		return v >>> $urandom_range(0, 31);
	endfunction

	task automatic send_random();
		int          pick;
		logic [1:0]  mode;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			mode = MODE_LOAD_K;
		else if (pick < 30)
			mode = MODE_LOAD_G;
		else if (pick < 35)
			mode = MODE_NONE;
		else
			mode = MODE_EVAL;
		send_word(mode, 10'($urandom()), $signed($urandom()), rand_comp(), rand_comp(),
			rand_comp());
	endtask

	// every entry written once, so no read ever hits an unwritten entry
	task automatic test_table_fill();
		logic signed [31:0] k;
		logic signed [31:0] g;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			// smooth falling kernel, mostly negative gradient factor
			k = 32'sd65536 - 32'(i * 64);
			g = -32'sd2000 * 32'(i % 37) + 32'sd10000;
			send_word(MODE_LOAD_K, 10'(i), k, '0, '0, '0);
			send_word(MODE_LOAD_G, 10'(i), g, '0, '0, '0);
		end
		drain();
	endtask

	task automatic test_directed();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		reg_write(REG_INV_RADIUS, INV_RADIUS_RESET);
		// zero offset: q is 0, gradient zero, kernel from entry 0
		send_word(MODE_EVAL, '0, '0, '0, '0, '0);
		// exactly on the support edge: top of table
		send_word(MODE_EVAL, '0, '0, 32'sd65536, '0, '0);
		send_word(MODE_EVAL, '0, '0, '0, -32'sd65536, '0);
		// just outside support
		send_word(MODE_EVAL, '0, '0, '0, '0, 32'sd65537);
		// extreme components: huge length, well outside support
		send_word(MODE_EVAL, '0, '0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_word(MODE_EVAL, '0, '0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		send_word(MODE_EVAL, '0, '0, -32'sd1, 32'sd1, -32'sd1);
		send_word(MODE_EVAL, '0, '0, 32'sd20000, -32'sd30000, 32'sd12345);
		// edge table words, top index, unused mode
		send_word(MODE_LOAD_K, 10'd1023, 32'sh7FFFFFFF, '0, '0, '0);
		send_word(MODE_LOAD_G, 10'd1023, 32'sh80000000, '0, '0, '0);
		send_word(MODE_LOAD_K, 10'd1022, 32'sh80000000, '0, '0, '0);
		send_word(MODE_LOAD_G, 10'd1022, 32'sh7FFFFFFF, '0, '0, '0);
		send_word(MODE_NONE, 10'h3FF, 32'shFFFFFFFF, 32'sh7FFFFFFF, '0, '0);
		// interpolation across the extreme pair, saturating gradient
		send_word(MODE_EVAL, '0, '0, 32'sd65500, '0, '0);
		send_word(MODE_EVAL, '0, '0, '0, '0, -32'sd65530);
		send_word(MODE_EVAL, '0, '0, 32'sd65536, '0, '0);
		send_word(MODE_LOAD_G, 10'd0, 32'sh7FFFFFFF, '0, '0, '0);
		send_word(MODE_EVAL, '0, '0, 32'sd1, '0, '0);
		drain();
		// zero radius inverse: q always 0
		reg_write(REG_INV_RADIUS, 32'd0);
		send_word(MODE_EVAL, '0, '0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd5);
		drain();
		// largest inverse: only an offset of 1 stays inside
		reg_write(REG_INV_RADIUS, 32'hFFFFFFFF);
		send_word(MODE_EVAL, '0, '0, 32'sd1, '0, '0);
		send_word(MODE_EVAL, '0, '0, '0, 32'sd2, '0);
		send_word(MODE_EVAL, '0, '0, 32'sh80000000, '0, '0);
		drain();
	endtask

	task automatic test_random_phase(input logic [31:0] radius_inv, input int idle_pct,
			input int stall_pct, input int count);
		reg_write(REG_INV_RADIUS, radius_inv);
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			send_random();
		drain();
	endtask

	// receiver holds off long enough to fill the pipe and back up the input
	task automatic test_backpressure();
		reg_write(REG_INV_RADIUS, 32'd131072);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_off = 300;
		for (int i = 0; i < 80; i++)
			send_random();
		drain();
	endtask

	// sender pauses mid-stream until every result is back
	task automatic test_sender_pause();
		reg_write(REG_INV_RADIUS, 32'd50000);
		src_idle_pct = 20;
		sink_stall_pct = 20;
		for (int i = 0; i < 30; i++)
			send_random();
		source_idle();
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < 30; i++)
			send_random();
		drain();
	endtask

	// receiver: random stalls, or a requested hold-off counted here
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_tready <= 1'b0;
				hold_off--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// result checker: each output word against the oldest expectation
	initial begin
		kresult_t e;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word %h", m_tdata);
					errors++;
				end else begin
					e = pending_results.pop_front();
					n_results++;
					if (m_tdata[31:0] !== e.kern) begin
						$error("kernel_value exp %h got %h", e.kern, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[63:32] !== e.gx) begin
						$error("grad_x exp %h got %h", e.gx, m_tdata[63:32]);
						errors++;
					end
					if (m_tdata[95:64] !== e.gy) begin
						$error("grad_y exp %h got %h", e.gy, m_tdata[95:64]);
						errors++;
					end
					if (m_tdata[127:96] !== e.gz) begin
						$error("grad_z exp %h got %h", e.gz, m_tdata[127:96]);
						errors++;
					end
				end
			end
		end
	end

	// watchdog: cycles with no handshake on any port
	initial begin
		dog = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				dog = 0;
			else
				dog++;
			if (dog >= DOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		n_words_in = 0;
		n_results = 0;
		n_outside = 0;
		n_zero_q = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_off = 0;
		inv_rad = INV_RADIUS_RESET;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_fill();
		test_directed();
		test_random_phase(32'd65536, 0, 0, 120);
		test_random_phase(32'd131072, 72, 0, 120);
		test_random_phase($urandom(), 0, 72, 120);
		test_random_phase(32'hFFFFFFFF, 20, 20, 60);
		test_random_phase(32'd0, 20, 20, 40);
		test_random_phase(32'd30000, 20, 20, 60);
		test_backpressure();
		test_sender_pause();

		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		$display("tb: %0d words in, %0d results checked (%0d outside support, %0d zero q)",
			n_words_in, n_results, n_outside, n_zero_q);
		$display("tb: radius settings incl. 0 and max, idle/stall mixes, long hold-off");
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sph_kte_pkg.sv
rtl/core/sph_kernel_table_eval_top.sv
rtl/core/sph_kte_chk.sv
tb/sv/tb.sv
